@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define RAE_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RAE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/rae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rae_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SCORE_BITS_DEF  = 32;

    localparam int S_DATA_W   = 32;
    localparam int AUC_W      = 17;
    localparam int TOTAL_W    = 9;
    localparam int PAIRS_W    = 15;
    localparam int STATUS_W   = 2;
    localparam int M_FIELDS_W = AUC_W + 2 * TOTAL_W + PAIRS_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ONE_SIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic valid;
        logic pos;
        logic last;
        logic dropped;
    } tok_ctl_t;

    typedef struct packed {
        logic busy;
        logic done_fire;
    } div_stat_t;

endpackage

`default_nettype wire

@@ design/rae_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rae_cell
    import rae_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int SCORE_BITS = SCORE_BITS_DEF,
    parameter int CNT_W      = 9
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tok_ctl_t              in_ctl,
    input  wire logic [SCORE_BITS-1:0] in_key,
    input  wire logic [CNT_W-1:0]      in_slot,
    input  wire logic [CNT_W-1:0]      in_wins,
    output tok_ctl_t                   out_ctl,
    output logic [SCORE_BITS-1:0]      out_key,
    output logic [CNT_W-1:0]           out_slot,
    output logic [CNT_W-1:0]           out_wins
);

    tok_ctl_t              ctl_reg;
    logic [SCORE_BITS-1:0] key_reg;
    logic [CNT_W-1:0]      slot_reg;
    logic [CNT_W-1:0]      wins_reg;
    logic [CNT_W-1:0]      wins_next;
    logic                  held_pos_reg;
    logic [SCORE_BITS-1:0] held_key_reg;
    logic                  active;
    logic                  occupied;
    logic                  win;
    logic                  write_en;

    assign active   = in_ctl.valid && !in_ctl.dropped;
    assign occupied = CNT_W'(INDEX) < in_slot;
    assign write_en = active && (in_slot == CNT_W'(INDEX));

    always_comb
    begin
        if (in_ctl.pos)
        begin
            win = !held_pos_reg && ($signed(held_key_reg) < $signed(in_key));
        end
        else
        begin
            win = held_pos_reg && ($signed(held_key_reg) > $signed(in_key));
        end
        wins_next = in_wins + CNT_W'(active && occupied && win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= in_key;
        slot_reg <= in_slot;
        wins_reg <= wins_next;
        if (write_en)
        begin
            held_pos_reg <= in_ctl.pos;
            held_key_reg <= in_key;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_key  = key_reg;
    assign out_slot = slot_reg;
    assign out_wins = wins_reg;

endmodule

`default_nettype wire

@@ design/rae_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rae_div
    import rae_pkg::*;
#(
    parameter int CNT_W = 9
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [CNT_W-1:0]    pos_in,
    input  wire logic [CNT_W-1:0]    neg_in,
    input  wire logic [2*CNT_W-1:0]  pair_in,
    input  wire logic                ovf_in,
    output div_stat_t                stat,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata,  // auc_value, positive_total,
                                                    // negative_total, winning_pairs
    output logic [STATUS_W-1:0]      m_axis_tuser   // status
);

    localparam int PAIR_W = 2 * CNT_W;
    localparam int STEP_W = $clog2(AUC_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg,  state_next;
    logic [CNT_W-1:0]      pos_reg,    pos_next;
    logic [CNT_W-1:0]      neg_reg,    neg_next;
    logic [PAIR_W-1:0]     pair_reg,   pair_next;
    logic                  ovf_reg,    ovf_next;
    logic [PAIR_W-1:0]     den_reg,    den_next;
    logic [PAIR_W:0]       rem_reg,    rem_next;
    logic [AUC_W-1:0]      quo_reg,    quo_next;
    logic [STEP_W-1:0]     step_reg,   step_next;
    logic                  one_side_reg, one_side_next;
    logic                  mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0]   mdata_reg,  mdata_next;
    logic [STATUS_W-1:0]   muser_reg,  muser_next;
    logic [PAIR_W:0]       shifted;
    logic                  ge;
    logic                  load_out;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        pair_next     = pair_reg;
        ovf_next      = ovf_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        one_side_next = one_side_reg;
        mvalid_next   = mvalid_reg && !m_axis_tready;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;
        load_out      = 1'b0;

        shifted = (step_reg == '0) ? rem_reg : {rem_reg[PAIR_W-1:0], 1'b0};
        ge      = shifted >= {1'b0, den_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next   = pos_in;
                    neg_next   = neg_in;
                    pair_next  = pair_in;
                    ovf_next   = ovf_in;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                den_next      = pos_reg * neg_reg;
                rem_next      = {1'b0, pair_reg};
                quo_next      = '0;
                step_next     = '0;
                one_side_next = (pos_reg == '0) || (neg_reg == '0);
                state_next    = one_side_next ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
                quo_next = {quo_reg[AUC_W-2:0], ge};
                if (step_reg == STEP_W'(AUC_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    load_out    = 1'b1;
                    mvalid_next = 1'b1;
                    mdata_next  = M_DATA_W'({PAIRS_W'(pair_reg), TOTAL_W'(neg_reg),
                                             TOTAL_W'(pos_reg), quo_reg});
                    if (one_side_reg)
                    begin
                        muser_next = STATUS_ONE_SIDE;
                    end
                    else if (ovf_reg)
                    begin
                        muser_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        muser_next = STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        pair_reg     <= pair_next;
        ovf_reg      <= ovf_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= one_side_next && (state_reg == ST_MUL) ? '0 : quo_next;
        step_reg     <= step_next;
        one_side_reg <= one_side_next;
        mdata_reg    <= mdata_next;
        muser_reg    <= muser_next;
    end

    assign stat.busy      = state_reg != ST_IDLE;
    assign stat.done_fire = load_out;
    assign m_axis_tvalid  = mvalid_reg;
    assign m_axis_tdata   = mdata_reg;
    assign m_axis_tuser   = muser_reg;

endmodule

`default_nettype wire

@@ design/roc_auc_engine.sv @@
// Channel  | Direction | Carries
// s_axis   | in        | tuser: label_positive; tdata: score; tlast: last_item
// m_axis   | out       | tdata: auc, totals, winning pairs; tuser: status
//
// One sample request is accepted per cycle while a set is open.
// Each sample walks a chain of MAX_SAMPLES cells, one cell per cycle.
// The closing request holds tready low while it passes the MAX_SAMPLES chain cells,
// one multiply, 17 divide steps (skipped when one side is empty) and the output load.
// The load waits longer while the output register still holds an unread result.
// Reset is asynchronous and active low; a stalled output never stops the chain.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module roc_auc_engine
    import rae_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // score
    input  wire logic                s_axis_tuser,  // label_positive
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata,  // auc_value, positive_total,
                                                    // negative_total, winning_pairs
    output logic [STATUS_W-1:0]      m_axis_tuser   // status
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PAIR_W = 2 * CNT_W;

    tok_ctl_t              chain_ctl  [0:MAX_SAMPLES];
    logic [SCORE_BITS-1:0] chain_key  [0:MAX_SAMPLES];
    logic [CNT_W-1:0]      chain_slot [0:MAX_SAMPLES];
    logic [CNT_W-1:0]      chain_wins [0:MAX_SAMPLES];

    logic                  s_fire;
    logic                  dropped;
    logic                  closing_reg, closing_next;
    logic [CNT_W-1:0]      in_count_reg, in_count_next;
    logic [CNT_W-1:0]      pos_acc_reg, pos_acc_next;
    logic [CNT_W-1:0]      neg_acc_reg, neg_acc_next;
    logic [PAIR_W-1:0]     pair_acc_reg, pair_acc_next;
    logic                  ovf_acc_reg, ovf_acc_next;
    logic [CNT_W-1:0]      pos_sum;
    logic [CNT_W-1:0]      neg_sum;
    logic [PAIR_W-1:0]     pair_sum;
    logic                  ovf_sum;
    logic                  div_start;
    div_stat_t             div_stat;
    tok_ctl_t              tail_ctl;

    assign s_axis_tready = !closing_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign dropped       = in_count_reg == CNT_W'(MAX_SAMPLES);

    assign chain_ctl[0].valid   = s_fire;
    assign chain_ctl[0].pos     = s_axis_tuser;
    assign chain_ctl[0].last    = s_axis_tlast;
    assign chain_ctl[0].dropped = dropped;
    assign chain_slot[0]        = in_count_reg;
    assign chain_wins[0]        = '0;

    generate
        if (SCORE_BITS <= S_DATA_W)
        begin : g_key_narrow
            assign chain_key[0] = s_axis_tdata[SCORE_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign chain_key[0] = {{(SCORE_BITS - S_DATA_W){1'b0}}, s_axis_tdata};
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_cell
            rae_cell #(
                .INDEX      (gi),
                .SCORE_BITS (SCORE_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_ctl   (chain_ctl[gi]),
                .in_key   (chain_key[gi]),
                .in_slot  (chain_slot[gi]),
                .in_wins  (chain_wins[gi]),
                .out_ctl  (chain_ctl[gi+1]),
                .out_key  (chain_key[gi+1]),
                .out_slot (chain_slot[gi+1]),
                .out_wins (chain_wins[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        in_count_next = in_count_reg;
        closing_next  = closing_reg;
        if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                in_count_next = '0;
                closing_next  = 1'b1;
            end
            else if (!dropped)
            begin
                in_count_next = in_count_reg + CNT_W'(1);
            end
        end
        if (div_stat.done_fire)
        begin
            closing_next = 1'b0;
        end
    end

    assign tail_ctl = chain_ctl[MAX_SAMPLES];

    always_comb
    begin
        pos_sum  = pos_acc_reg;
        neg_sum  = neg_acc_reg;
        pair_sum = pair_acc_reg;
        ovf_sum  = ovf_acc_reg;
        if (tail_ctl.valid)
        begin
            if (tail_ctl.dropped)
            begin
                ovf_sum = 1'b1;
            end
            else
            begin
                pair_sum = pair_acc_reg + PAIR_W'(chain_wins[MAX_SAMPLES]);
                if (tail_ctl.pos)
                begin
                    pos_sum = pos_acc_reg + CNT_W'(1);
                end
                else
                begin
                    neg_sum = neg_acc_reg + CNT_W'(1);
                end
            end
        end
        div_start = tail_ctl.valid && tail_ctl.last;
        if (div_start)
        begin
            pos_acc_next  = '0;
            neg_acc_next  = '0;
            pair_acc_next = '0;
            ovf_acc_next  = 1'b0;
        end
        else
        begin
            pos_acc_next  = pos_sum;
            neg_acc_next  = neg_sum;
            pair_acc_next = pair_sum;
            ovf_acc_next  = ovf_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closing_reg  <= 1'b0;
            in_count_reg <= '0;
            pos_acc_reg  <= '0;
            neg_acc_reg  <= '0;
            pair_acc_reg <= '0;
            ovf_acc_reg  <= 1'b0;
        end
        else
        begin
            closing_reg  <= closing_next;
            in_count_reg <= in_count_next;
            pos_acc_reg  <= pos_acc_next;
            neg_acc_reg  <= neg_acc_next;
            pair_acc_reg <= pair_acc_next;
            ovf_acc_reg  <= ovf_acc_next;
        end
    end

    rae_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .pos_in        (pos_sum),
        .neg_in        (neg_sum),
        .pair_in       (pair_sum),
        .ovf_in        (ovf_sum),
        .stat          (div_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `RAE_ASSERT_IMPL(a_tail_div_idle, div_start, !div_stat.busy, "closing sample met a busy divider")
    `RAE_ASSERT_IMPL(a_div_in_close, div_stat.busy, closing_reg, "divider busy with no set closing")
    `RAE_ASSERT_IMPL(a_result_opens, $rose(m_axis_tvalid), !closing_reg, "result loaded with input shut")
    `RAE_ASSERT(a_fill_bound, in_count_reg <= CNT_W'(MAX_SAMPLES), "fill count past capacity")

endmodule

`default_nettype wire
